FILE: hw/rtl/mps_pkg.sv
// Package of the masked pattern scanner: sizes, register index codes and
// the structs passed between the scanner modules. No dependencies.
package mps_pkg;

  localparam int MaxPattern = 16;
  localparam int AddrWidth  = 32;
  localparam int ByteWidth  = 8;
  localparam int CountWidth = 16;
  localparam int LenWidth   = 5;
  localparam int CellIdxW   = $clog2(MaxPattern);
  localparam int CfgWidth   = 64;
  localparam int CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow  = 2'd0,
    CfgPatternHigh = 2'd1,
    CfgCompareMask = 2'd2,
    CfgPatternLen  = 2'd3
  } cfg_reg_e;

  // one evaluated window position handed to the tally
  typedef struct packed {
    logic                advance;
    logic                hit;
    logic                last;
    logic [LenWidth-1:0] len;
  } step_t;

  typedef struct packed {
    logic [CountWidth-1:0] total;
    logic [AddrWidth-1:0]  addr;
    logic                  unique_hit;
  } result_t;

endpackage

FILE: hw/rtl/mps_cell.sv
// One window cell of the masked pattern scanner: holds one byte and its
// fill bit, passes both on to the next cell. Uses mps_pkg.
module mps_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [mps_pkg::ByteWidth-1:0] byte_i,
  input  logic                         valid_i,
  input  logic [mps_pkg::ByteWidth-1:0] expect_i,
  input  logic                         care_i,
  output logic [mps_pkg::ByteWidth-1:0] byte_o,
  output logic                         valid_o,
  output logic                         hit_o
);
  import mps_pkg::*;

  logic [ByteWidth-1:0] byte_q, byte_d;
  logic                 valid_q, valid_d;

  always_comb begin
    byte_d  = byte_q;
    valid_d = valid_q;
    if (shift_i) begin
      byte_d  = byte_i;
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // don't-care positions always pass
  assign hit_o   = !care_i || (byte_q == expect_i);
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

FILE: hw/rtl/mps_tally.sv
// Match counter, last-match address and result register of the masked
// pattern scanner. Uses mps_pkg.
module mps_tally (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mps_pkg::step_t                step_i,
  input  logic [mps_pkg::AddrWidth-1:0] addr_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output mps_pkg::result_t              result_o,
  output logic                          busy_o
);
  import mps_pkg::*;

  logic [CountWidth-1:0] cnt_q, cnt_d, cnt_new;
  logic [AddrWidth-1:0]  last_addr_q, last_addr_d, addr_new, hit_addr;
  logic                  out_valid_q, out_valid_d;
  result_t               result_q, result_d;

  assign hit_addr = addr_i - {{(AddrWidth-LenWidth){1'b0}}, step_i.len} + AddrWidth'(1);

  always_comb begin
    cnt_new  = cnt_q;
    addr_new = last_addr_q;
    if (step_i.hit) begin
      if (cnt_q != {CountWidth{1'b1}}) cnt_new = cnt_q + CountWidth'(1);
      addr_new = hit_addr;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    last_addr_d = last_addr_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step_i.advance) begin
      cnt_d       = cnt_new;
      last_addr_d = addr_new;
      if (step_i.last) begin
        result_d.total      = cnt_new;
        result_d.addr       = (cnt_new != '0) ? addr_new : '0;
        result_d.unique_hit = (cnt_new == CountWidth'(1));
        out_valid_d         = 1'b1;
        cnt_d               = '0;
        last_addr_d         = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      last_addr_q <= last_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign busy_o      = out_valid_q && !out_ready_i;

endmodule

FILE: hw/rtl/masked_pattern_scanner_core.sv
// Top level of the masked pattern scanner: config registers, the row of
// window cells and the evaluation stage. Uses mps_pkg, mps_cell, mps_tally.
//
//  channel   dir  handshake                       content
//  s_axis    in   s_axis_tvalid / s_axis_tready   byte, address, section start, scan end
//  m_axis    out  m_axis_tvalid / m_axis_tready   match total, address, unique flag
//  cfg       in   cfg_valid_i / cfg_ready_o       register index, 64-bit data
//
// One byte per cycle is accepted while s_axis_tready is high and goes into
// cell 0 of the 16-cell window and the evaluation stage; all cells compare
// against the aligned pattern in parallel and the tally updates as the stage
// advances. A scan-end byte leaving the stage registers a result for m_axis.
// s_axis_tready drops only while a scan-end byte waits in the evaluation
// stage and the previous result is still not taken. Reset clears fill bits,
// counters and handshake state; cfg_ready_o is always high.
module masked_pattern_scanner_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mps_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mps_pkg::CfgWidth-1:0]    cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,  // [7:0] data_byte, [39:8] byte_address
  input  logic                            s_axis_tuser,  // [0] section_start
  input  logic                            s_axis_tlast,  // scan_end
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [47:0]                     m_axis_tdata,  // [31:0] match_address, [47:32] match_total
  output logic                            m_axis_tuser   // [0] unique_match
);
  import mps_pkg::*;

  // ---------------- config registers ----------------
  logic [2*CfgWidth-1:0] pattern_q, pattern_d;
  logic [MaxPattern-1:0] mask_q, mask_d;
  logic [LenWidth-1:0]   len_q, len_d;

  always_comb begin
    pattern_d = pattern_q;
    mask_d    = mask_q;
    len_d     = len_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgPatternLow:  pattern_d[CfgWidth-1:0]          = cfg_data_i;
        CfgPatternHigh: pattern_d[2*CfgWidth-1:CfgWidth] = cfg_data_i;
        CfgCompareMask: mask_d = cfg_data_i[MaxPattern-1:0];
        CfgPatternLen:  len_d  = cfg_data_i[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      mask_q    <= '1;
      len_q     <= '0;
    end else begin
      pattern_q <= pattern_d;
      mask_q    <= mask_d;
      len_q     <= len_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------- input side ----------------
  logic                 accept;
  logic                 stall;
  logic                 clear;
  logic                 after_end_q;
  logic [ByteWidth-1:0] in_byte;
  logic [AddrWidth-1:0] in_addr;

  assign in_byte = s_axis_tdata[ByteWidth-1:0];
  assign in_addr = s_axis_tdata[ByteWidth+AddrWidth-1:ByteWidth];
  assign accept  = s_axis_tvalid && s_axis_tready;
  // window restarts at a section start and after the previous scan ended
  assign clear   = s_axis_tuser || after_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_end_q <= 1'b0;
    end else if (accept) begin
      after_end_q <= s_axis_tlast;
    end
  end

  // ---------------- evaluation stage ----------------
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_last_q;
  logic [AddrWidth-1:0] s1_addr_q;
  logic                 advance;
  logic                 tally_busy;

  assign stall         = s1_valid_q && s1_last_q && tally_busy;
  assign s_axis_tready = !stall;
  assign advance       = s1_valid_q && !stall;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)       s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= s_axis_tlast;
      s1_addr_q <= in_addr;
    end
  end

  // ---------------- cell row ----------------
  // cell k holds the k-th newest byte; it lines up with pattern byte len-1-k
  logic [ByteWidth-1:0]  cell_byte  [MaxPattern];
  logic [ByteWidth-1:0]  cell_in    [MaxPattern];
  logic [ByteWidth-1:0]  cell_exp   [MaxPattern];
  logic [MaxPattern-1:0] cell_valid;
  logic [MaxPattern-1:0] cell_vin;
  logic [MaxPattern-1:0] cell_care;
  logic [MaxPattern-1:0] cell_hit;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic [LenWidth-1:0] pat_idx;
    assign pat_idx      = len_q - LenWidth'(k) - LenWidth'(1);
    assign cell_care[k] = (LenWidth'(k) < len_q) && mask_q[pat_idx[CellIdxW-1:0]];
    assign cell_exp[k]  = pattern_q[ByteWidth*pat_idx[CellIdxW-1:0] +: ByteWidth];

    if (k == 0) begin : g_head
      assign cell_in[k]  = in_byte;
      assign cell_vin[k] = 1'b1;
    end else begin : g_body
      assign cell_in[k]  = cell_byte[k-1];
      assign cell_vin[k] = cell_valid[k-1] && !clear;
    end

    mps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .byte_i   (cell_in[k]),
      .valid_i  (cell_vin[k]),
      .expect_i (cell_exp[k]),
      .care_i   (cell_care[k]),
      .byte_o   (cell_byte[k]),
      .valid_o  (cell_valid[k]),
      .hit_o    (cell_hit[k])
    );
  end

  // length 0 and lengths above the window never match
  logic                len_ok;
  logic [LenWidth-1:0] len_m1;
  logic                window_hit;

  assign len_ok     = (len_q != '0) && (len_q <= LenWidth'(MaxPattern));
  assign len_m1     = len_q - LenWidth'(1);
  assign window_hit = len_ok && cell_valid[len_m1[CellIdxW-1:0]] && (&cell_hit);

  // ---------------- tally and result register ----------------
  step_t   step;
  result_t result;

  assign step.advance = advance;
  assign step.hit     = advance && window_hit;
  assign step.last    = s1_last_q;
  assign step.len     = len_q;

  mps_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .addr_i      (s1_addr_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .result_o    (result),
    .busy_o      (tally_busy)
  );

  assign m_axis_tdata = {result.total, result.addr};
  assign m_axis_tuser = result.unique_hit;

`ifndef NO_ASSERTIONS
  // input only backs up behind a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && s1_valid_q))
    else $error("input stalled without a pending result");

  // unique flag only with a count of one
  a_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[47:32] == 16'd1))
    else $error("unique flag with count other than one");

  // zero matches report address zero
  a_no_match_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[47:32] == 16'd0)) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("address set without any match");

  // an accepted byte is held in the evaluation stage in the next cycle
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted byte missing from evaluation stage");

  // a scan-end byte that leaves the evaluation stage produces a result
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=> m_axis_tvalid)
    else $error("scan end produced no result");
`endif

endmodule
